/* rtl/core/four_vertex_switching_check_core_defines.svh */
// Assertion macros shared by the four-vertex switching check RTL.
// Defining ASSERT_OFF turns every use into an empty statement.
`ifndef FOUR_VERTEX_SWITCHING_CHECK_CORE_DEFINES_SVH
`define FOUR_VERTEX_SWITCHING_CHECK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FVSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fvsc assertion failed");
`define FVSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fvsc assertion failed");
`else
`define FVSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FVSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/fvsc_pkg.sv */
// Package for the four-vertex switching check: sizes, codes and state type.
// No dependencies; imported by four_vertex_switching_check_core.
package fvsc_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int ROW_W            = 64;
    localparam int VTX_W            = 6;
    localparam int COUNT_W          = 7;
    localparam int IN_DATA_W        = 96;
    localparam int IN_USER_W        = 2;
    localparam int OUT_DATA_W       = 72;

    localparam logic [2:0] SET_SIZE  = 3'd4;
    localparam logic [2:0] HALF_SET  = 3'd2;
    localparam logic [1:0] MASK_ROWS = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEST = 2'd1,
        CMD_MASK = 2'd2
    } fvsc_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_FINISH
    } fvsc_state_t;

endpackage

/* rtl/core/four_vertex_switching_check_core.sv */
// Four-vertex switching check: adjacency row store, row sweep sequencer and result stage.
// Depends on fvsc_pkg and four_vertex_switching_check_core_defines.svh.
//
//  channel  | direction | contents
//  s_       | in        | tuser: command; tdata: row_index, row_bits, vertex_a..vertex_d
//  m_       | out       | tdata: set_accepted, vertex_mask
//  cfg_     | in        | cfg_data: count of vertices in use
//
// A load, a rejected set or the unused command passes from decode straight to the result
// stage; a mask beat first sweeps the rows of vertex_a, vertex_b and vertex_c.
// A test beat sweeps all n rows, n being the vertex count in use: the single
// read port of the row memory supplies one row per cycle to the shared bit counter.
// Reset is synchronous; the vertex count returns to 64 and the row memory is not cleared.
// The input is not ready while a beat is being worked on or its result waits for the output register.
`include "four_vertex_switching_check_core_defines.svh"

module four_vertex_switching_check_core
    import fvsc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Bits from 0: row_index[6], row_bits[64], vertex_a[6], vertex_b[6],
    // vertex_c[6], vertex_d[6], zero fill.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Bits from 0: command[2].
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Bits from 0: set_accepted[1], vertex_mask[64], zero fill.
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_W-1:0]    cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [ROW_W-1:0] mem_rows [MAX_VERTICES];
    logic [ROW_W-1:0] rd_data_reg;

    fvsc_state_t state_reg, state_next;
    fvsc_cmd_t   cmd_reg, cmd_next;
    logic [COUNT_W-1:0] vcount_reg, vcount_next;
    logic [VTX_W-1:0] row_idx_reg, row_idx_next;
    logic [ROW_W-1:0] row_bits_reg, row_bits_next;
    logic [VTX_W-1:0] va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next, vd_reg, vd_next;
    logic             rej_reg, rej_next;
    logic [CW-1:0]    v_reg, v_next;
    logic             pv_reg, pv_next;
    logic [CW-1:0]    pidx_reg, pidx_next;
    logic             bad_reg, bad_next;
    logic             deg_seen_reg, deg_seen_next;
    logic [2:0]       deg_first_reg, deg_first_next;
    logic [ROW_W-1:0] mask_acc_reg, mask_acc_next;
    logic [ROW_W-1:0] row_a_reg, row_a_next, row_b_reg, row_b_next, row_c_reg, row_c_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_acc_reg, out_acc_next;
    logic [ROW_W-1:0] out_mask_reg, out_mask_next;

    logic [COUNT_W-1:0] eff_w;
    logic [CW-1:0]      eff_cw;
    logic [CW-1:0]      limit;
    logic               issue;
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic [VTX_W-1:0]   sel_vtx;
    logic               ok3, ok4;
    logic [2:0]         cnt;
    logic               inset;
    logic [VTX_W-1:0]   pidx6;
    logic               out_load;
    logic [ROW_W-1:0]   cmask;
    logic               e_ab, e_ac, e_bc;
    logic [1:0]         edges, deg0, deg1, deg2;
    logic [2:0]         pattern;
    logic [ROW_W-1:0]   comp_mask;
    logic               res_acc;
    logic [ROW_W-1:0]   res_mask;

    assign eff_w  = (vcount_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : vcount_reg;
    assign eff_cw = eff_w[CW-1:0];

    assign ok3 = ({1'b0, va_reg} < eff_w) && ({1'b0, vb_reg} < eff_w)
              && ({1'b0, vc_reg} < eff_w) && (va_reg != vb_reg)
              && (va_reg != vc_reg) && (vb_reg != vc_reg);
    assign ok4 = ok3 && ({1'b0, vd_reg} < eff_w) && (vd_reg != va_reg)
              && (vd_reg != vb_reg) && (vd_reg != vc_reg);

    assign limit = (cmd_reg == CMD_TEST) ? eff_cw : CW'(MASK_ROWS);
    assign issue = (state_reg == ST_SWEEP) && (v_reg < limit);

    always_comb begin
        case (v_reg[1:0])
            2'd0:    sel_vtx = va_reg;
            2'd1:    sel_vtx = vb_reg;
            default: sel_vtx = vc_reg;
        endcase
    end

    assign rd_addr = (cmd_reg == CMD_TEST) ? v_reg[AW-1:0] : sel_vtx[AW-1:0];
    assign wr_en   = (state_reg == ST_DECODE) && (cmd_reg == CMD_LOAD)
                  && ({1'b0, row_idx_reg} < COUNT_W'(MAX_VERTICES));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_rows[row_idx_reg[AW-1:0]] <= row_bits_reg;
        end
        if (issue) begin
            rd_data_reg <= mem_rows[rd_addr];
        end
    end

    // Shared counter: how many of the set vertices the row in flight touches.
    assign cnt = 3'(rd_data_reg[va_reg]) + 3'(rd_data_reg[vb_reg])
               + 3'(rd_data_reg[vc_reg]) + 3'(rd_data_reg[vd_reg]);
    assign pidx6 = VTX_W'(pidx_reg);
    assign inset = (pidx6 == va_reg) || (pidx6 == vb_reg)
                || (pidx6 == vc_reg) || (pidx6 == vd_reg);

    always_comb begin
        for (int i = 0; i < ROW_W; i++) begin
            cmask[i] = COUNT_W'(i) < eff_w;
        end
    end

    assign e_ab  = row_a_reg[vb_reg];
    assign e_ac  = row_a_reg[vc_reg];
    assign e_bc  = row_b_reg[vc_reg];
    assign edges = 2'(e_ab) + 2'(e_ac) + 2'(e_bc);
    assign deg0  = 2'(e_ab) + 2'(e_ac);
    assign deg1  = 2'(e_ab) + 2'(e_bc);
    assign deg2  = 2'(e_ac) + 2'(e_bc);

    always_comb begin
        case (edges)
            2'd1:    pattern = {deg2 == 2'd0, deg1 == 2'd0, deg0 == 2'd0};
            2'd2:    pattern = {deg2 == 2'd1, deg1 == 2'd1, deg0 == 2'd1};
            2'd3:    pattern = 3'b111;
            default: pattern = 3'b000;
        endcase
    end

    always_comb begin
        comp_mask = (pattern[0] ? row_a_reg : ~row_a_reg)
                  & (pattern[1] ? row_b_reg : ~row_b_reg)
                  & (pattern[2] ? row_c_reg : ~row_c_reg) & cmask;
        comp_mask[va_reg] = 1'b0;
        comp_mask[vb_reg] = 1'b0;
        comp_mask[vc_reg] = 1'b0;
    end

    always_comb begin
        res_acc  = 1'b0;
        res_mask = '0;
        if (!rej_reg) begin
            case (cmd_reg)
                CMD_TEST: begin
                    res_acc  = !bad_reg && (mask_acc_reg != '0);
                    res_mask = res_acc ? mask_acc_reg : '0;
                end
                CMD_MASK: begin
                    res_mask = comp_mask;
                end
                default: begin
                    res_mask = '0;
                end
            endcase
        end
    end

    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if ((cmd_reg == CMD_TEST && ok4) || (cmd_reg == CMD_MASK && ok3)) begin
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SWEEP: begin
                if (!issue && !pv_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        cfg_ready      = 1'b1;
        vcount_next    = (cfg_valid) ? cfg_data : vcount_reg;
        cmd_next       = cmd_reg;
        row_idx_next   = row_idx_reg;
        row_bits_next  = row_bits_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        vd_next        = vd_reg;
        rej_next       = rej_reg;
        v_next         = v_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        bad_next       = bad_reg;
        deg_seen_next  = deg_seen_reg;
        deg_first_next = deg_first_reg;
        mask_acc_next  = mask_acc_reg;
        row_a_next     = row_a_reg;
        row_b_next     = row_b_reg;
        row_c_next     = row_c_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_acc_next   = out_acc_reg;
        out_mask_next  = out_mask_reg;

        if (s_tvalid && s_tready) begin
            cmd_next      = fvsc_cmd_t'(s_tuser);
            row_idx_next  = s_tdata[5:0];
            row_bits_next = s_tdata[69:6];
            va_next       = s_tdata[75:70];
            vb_next       = s_tdata[81:76];
            vc_next       = s_tdata[87:82];
            vd_next       = s_tdata[93:88];
        end

        if (state_reg == ST_DECODE) begin
            rej_next      = !((cmd_reg == CMD_TEST && ok4) || (cmd_reg == CMD_MASK && ok3));
            v_next        = '0;
            bad_next      = 1'b0;
            deg_seen_next = 1'b0;
            mask_acc_next = '0;
        end

        if (issue) begin
            v_next    = v_reg + CW'(1);
            pv_next   = 1'b1;
            pidx_next = v_reg;
        end

        if (pv_reg) begin
            if (cmd_reg == CMD_TEST) begin
                if (inset) begin
                    if (!deg_seen_reg) begin
                        deg_seen_next  = 1'b1;
                        deg_first_next = cnt;
                    end else if (cnt != deg_first_reg) begin
                        bad_next = 1'b1;
                    end
                end else if (cnt == HALF_SET) begin
                    mask_acc_next[pidx6] = 1'b1;
                end else if (cnt != 3'd0 && cnt != SET_SIZE) begin
                    bad_next = 1'b1;
                end
            end else begin
                case (pidx_reg[1:0])
                    2'd0:    row_a_next = rd_data_reg;
                    2'd1:    row_b_next = rd_data_reg;
                    2'd2:    row_c_next = rd_data_reg;
                    default: row_c_next = row_c_reg;
                endcase
            end
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            out_acc_next  = res_acc;
            out_mask_next = res_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= COUNT_W'(64);
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        row_idx_reg   <= row_idx_next;
        row_bits_reg  <= row_bits_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        vc_reg        <= vc_next;
        vd_reg        <= vd_next;
        rej_reg       <= rej_next;
        v_reg         <= v_next;
        pidx_reg      <= pidx_next;
        bad_reg       <= bad_next;
        deg_seen_reg  <= deg_seen_next;
        deg_first_reg <= deg_first_next;
        mask_acc_reg  <= mask_acc_next;
        row_a_reg     <= row_a_next;
        row_b_reg     <= row_b_next;
        row_c_reg     <= row_c_next;
        out_acc_reg   <= out_acc_next;
        out_mask_reg  <= out_mask_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - ROW_W - 1)'(0), out_mask_reg, out_acc_reg};

    `FVSC_ASSERT_IMP(a_acc_has_mask, aclk, aresetn, m_tvalid_reg && out_acc_reg, out_mask_reg != '0)
    `FVSC_ASSERT_IMP(a_drained_at_finish, aclk, aresetn, state_reg == ST_FINISH, !pv_reg)
    `FVSC_ASSERT_IMP(a_read_in_sweep, aclk, aresetn, pv_reg, state_reg == ST_SWEEP)
    `FVSC_ASSERT_NXT(a_accept_decodes, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECODE)
    `FVSC_ASSERT_IMP(a_mask_reads_three, aclk, aresetn,
        state_reg == ST_SWEEP && cmd_reg == CMD_MASK, v_reg <= CW'(MASK_ROWS))

endmodule

/* verif/tb_four_vertex_switching_check_core.sv */
// Self-checking testbench for four_vertex_switching_check_core: planted switching sets,
// random queries and a list of vertex counts, with stalls on both streams. Depends on fvsc_pkg.
module tb_four_vertex_switching_check_core
    import fvsc_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         PHASES         = 15;
    localparam int         PHASE_BEATS    = 66;
    localparam int         LONG_HOLD      = 400;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  vertex_d;
        logic [5:0]  vertex_c;
        logic [5:0]  vertex_b;
        logic [5:0]  vertex_a;
        logic [63:0] row_bits;
        logic [5:0]  row_index;
    } switch_beat_t;

    typedef struct packed {
        logic [63:0] vertex_mask;
        logic        set_accepted;
    } switch_outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [COUNT_W-1:0]    cfg_data = '0;

    switch_beat_t    pending_beats[$];
    switch_outcome_t awaited_outcomes[$];
    switch_beat_t    drive_beat;
    switch_outcome_t head_outcome;
    logic [63:0]     adj_rows_model [64];
    logic [6:0]      count_model = 7'd64;
    logic            s_beat_taken = 1'b0;
    int              idle_cycles = 0;
    int              fail_count = 0;
    int              queued_in_phase = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              rx_hold_left = 0;
    bit              long_hold_req = 1'b0;
    bit              long_hold_done = 1'b0;

    four_vertex_switching_check_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int effective_count();
        return (count_model > 7'd64) ? 64 : int'(count_model);
    endfunction

    function automatic logic [63:0] low_mask(input int n);
        if (n <= 0) return 64'd0;
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic bit all_distinct_below(input logic [3:0][5:0] sv, input int k,
                                              input int n);
        int i, j;
        for (i = 0; i < k; i++) begin
            if (int'(sv[i]) >= n) return 1'b0;
            for (j = i + 1; j < k; j++)
                if (sv[i] == sv[j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic switch_outcome_t switching_test(input logic [3:0][5:0] sv, input int n);
        switch_outcome_t res;
        logic [63:0]     m;
        int              i, j, v, deg, deg0, cnt;
        bit              inset;
        res = '0;
        m = '0;
        deg0 = 0;
        for (i = 0; i < 4; i++) begin
            deg = 0;
            for (j = 0; j < 4; j++) deg += int'(adj_rows_model[sv[i]][sv[j]]);
            if (i == 0) deg0 = deg;
            else if (deg != deg0) return res;
        end
        for (v = 0; v < n; v++) begin
            cnt = 0;
            inset = 1'b0;
            for (j = 0; j < 4; j++) begin
                if (int'(sv[j]) == v) inset = 1'b1;
                cnt += int'(adj_rows_model[v][sv[j]]);
            end
            if (inset) continue;
            if (cnt == 2) m[v] = 1'b1;
            else if (cnt != 0 && cnt != 4) return res;
        end
        if (m == 64'd0) return res;
        res.set_accepted = 1'b1;
        res.vertex_mask = m;
        return res;
    endfunction

    function automatic logic [63:0] fourth_mask(input logic [3:0][5:0] sv, input int n);
        int          e_ab, e_ac, e_bc, deg_a, deg_b, deg_c, sum, i;
        logic [2:0]  pattern;
        logic [63:0] m;
        e_ab = int'(adj_rows_model[sv[0]][sv[1]]);
        e_ac = int'(adj_rows_model[sv[0]][sv[2]]);
        e_bc = int'(adj_rows_model[sv[1]][sv[2]]);
        deg_a = e_ab + e_ac;
        deg_b = e_ab + e_bc;
        deg_c = e_ac + e_bc;
        sum = deg_a + deg_b + deg_c;
        pattern = 3'b000;
        if (sum == 6) pattern = 3'b111;
        else if (sum == 2) pattern = {deg_c == 0, deg_b == 0, deg_a == 0};
        else if (sum == 4) pattern = {deg_c == 1, deg_b == 1, deg_a == 1};
        m = '1;
        for (i = 0; i < 3; i++)
            m &= pattern[i] ? adj_rows_model[sv[i]] : ~adj_rows_model[sv[i]];
        for (i = 0; i < 3; i++) m[sv[i]] = 1'b0;
        return m & low_mask(n);
    endfunction

    function automatic switch_outcome_t switching_outcome(input logic [1:0] cmd,
                                                          input logic [IN_DATA_W-1:0] data);
        switch_outcome_t  res;
        logic [3:0][5:0]  sv;
        int               n;
        res = '0;
        sv = data[93:70];
        n = effective_count();
        case (cmd)
            CMD_LOAD: adj_rows_model[data[5:0]] = data[69:6];
            CMD_TEST: if (all_distinct_below(sv, 4, n)) res = switching_test(sv, n);
            CMD_MASK: if (all_distinct_below(sv, 3, n)) res.vertex_mask = fourth_mask(sv, n);
            default: ;
        endcase
        return res;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= drive_beat.command;
                s_tdata <= {2'b00, drive_beat.vertex_d, drive_beat.vertex_c, drive_beat.vertex_b,
                            drive_beat.vertex_a, drive_beat.row_bits, drive_beat.row_index};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (long_hold_req && !long_hold_done) begin
                rx_hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_beat_taken <= 1'b0;
            count_model = 7'd64;
            idle_cycles = 0;
        end else begin
            s_beat_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) count_model = cfg_data;
            if (s_tvalid && s_tready) awaited_outcomes.push_back(switching_outcome(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result beat with no expected result: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    head_outcome = awaited_outcomes.pop_front();
                    if (m_tdata[0] !== head_outcome.set_accepted) begin
                        $error("set_accepted: expected %0d, got %0d",
                               head_outcome.set_accepted, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[64:1] !== head_outcome.vertex_mask) begin
                        $error("vertex_mask: expected %h, got %h",
                               head_outcome.vertex_mask, m_tdata[64:1]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_row();
        case ($urandom_range(15))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0][5:0] pick_distinct(input int lim, input int k);
        logic [3:0][5:0] sv;
        int              i, j;
        bit              clash;
        for (i = 0; i < 4; i++) sv[i] = 6'($urandom_range(63));
        for (i = 0; i < k; i++) begin
            do begin
                sv[i] = 6'($urandom_range(lim - 1));
                clash = 1'b0;
                for (j = 0; j < i; j++) if (sv[j] == sv[i]) clash = 1'b1;
            end while (clash);
        end
        return sv;
    endfunction

    function automatic int set_slot(input logic [3:0][5:0] sv, input int v);
        int j;
        for (j = 0; j < 4; j++) if (int'(sv[j]) == v) return j;
        return -1;
    endfunction

    function automatic logic [3:0][5:0] shuffled(input logic [3:0][5:0] sv);
        logic [3:0][5:0] p;
        logic [5:0]      tmp;
        int              i, k;
        p = sv;
        for (i = 3; i > 0; i--) begin
            k = $urandom_range(i);
            tmp = p[i];
            p[i] = p[k];
            p[k] = tmp;
        end
        return p;
    endfunction

    task automatic queue_beat(input logic [1:0] cmd, input logic [5:0] idx,
                              input logic [63:0] bits, input logic [3:0][5:0] sv);
        switch_beat_t b;
        b.command = cmd;
        b.row_index = idx;
        b.row_bits = bits;
        b.vertex_a = sv[0];
        b.vertex_b = sv[1];
        b.vertex_c = sv[2];
        b.vertex_d = sv[3];
        pending_beats.push_back(b);
        queued_in_phase++;
    endtask

    // Loads every row below n so that a random set of four mostly has a regular induced subgraph
    // and outside vertices touching 0, 2 or 4 of it, with occasional flaws, then queries that set.
    task automatic queue_planted_graph(input int n);
        logic [3:0][5:0] sv, perm;
        logic [3:0][3:0] inner;
        logic [3:0]      touch;
        logic [63:0]     row;
        int              i, j, v, slot, forced, cnt;
        bit              flaw;
        sv = pick_distinct(n, 4);
        inner = '0;
        case ($urandom_range(3))
            1: begin
                inner[0][1] = 1'b1; inner[1][0] = 1'b1;
                inner[2][3] = 1'b1; inner[3][2] = 1'b1;
            end
            2: for (i = 0; i < 4; i++) begin
                inner[i][(i + 1) % 4] = 1'b1;
                inner[(i + 1) % 4][i] = 1'b1;
            end
            3: for (i = 0; i < 4; i++)
                for (j = 0; j < 4; j++) inner[i][j] = (i != j);
            default: ;
        endcase
        flaw = ($urandom_range(7) == 0);
        if (flaw) begin
            i = $urandom_range(3);
            j = (i + 1 + $urandom_range(2)) % 4;
            inner[i][j] = ~inner[i][j];
        end
        do forced = $urandom_range(n - 1); while (set_slot(sv, forced) >= 0);
        for (v = 0; v < n; v++) begin
            row = rand_row();
            slot = set_slot(sv, v);
            if (slot >= 0) begin
                for (j = 0; j < 4; j++) row[sv[j]] = inner[slot][j];
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3: cnt = 0;
                    4, 5, 6:    cnt = 2;
                    default:    cnt = 4;
                endcase
                if (v == forced) cnt = 2;
                else if (!flaw && $urandom_range(24) == 0) cnt = 1 + 2 * $urandom_range(1);
                touch = 4'b0000;
                while ($countones(touch) < cnt) touch[$urandom_range(3)] = 1'b1;
                for (j = 0; j < 4; j++) row[sv[j]] = touch[j];
            end
            queue_beat(CMD_LOAD, 6'(v), row, pick_distinct(64, 0));
        end
        queue_beat(CMD_TEST, 6'($urandom_range(63)), rand_row(), shuffled(sv));
        perm = shuffled(sv);
        queue_beat(CMD_MASK, 6'($urandom_range(63)), rand_row(), perm);
        if ($urandom_range(1) == 1) begin
            perm = shuffled(sv);
            queue_beat(CMD_TEST, 6'($urandom_range(63)), rand_row(), perm);
            queue_beat(CMD_MASK, 6'($urandom_range(63)), rand_row(), perm);
        end
    endtask

    task automatic queue_noise_beat(input int n);
        logic [3:0][5:0] sv;
        int              pick;
        pick = $urandom_range(9);
        sv = pick_distinct(64, 0);
        if (pick <= 2) begin
            queue_beat(CMD_LOAD, 6'($urandom_range(63)), rand_row(), sv);
        end else if (pick <= 5) begin
            if (n >= 4 && $urandom_range(3) != 0) sv = pick_distinct(n, 4);
            else if ($urandom_range(1) == 1) sv[3] = sv[$urandom_range(2)];
            queue_beat(CMD_TEST, 6'($urandom_range(63)), rand_row(), sv);
        end else if (pick <= 8) begin
            if (n >= 3 && $urandom_range(3) != 0) sv = pick_distinct(n, 3);
            else if ($urandom_range(1) == 1) sv[2] = sv[$urandom_range(1)];
            queue_beat(CMD_MASK, 6'($urandom_range(63)), rand_row(), sv);
        end else begin
            queue_beat(CMD_UNUSED, 6'($urandom_range(63)), rand_row(), sv);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_tvalid || awaited_outcomes.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_count_reg(input logic [6:0] count);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [6:0] phase_count(input int p);
        case (p)
            1:  return 7'd8;
            2:  return 7'd0;
            3:  return 7'd1;
            4:  return 7'd5;
            5:  return 7'd127;
            6:  return 7'd4;
            7:  return 7'd12;
            8:  return 7'd6;
            9:  return 7'd100;
            10: return 7'd10;
            11: return 7'd64;
            12: return 7'd7;
            13: return 7'd16;
            14: return 7'd9;
            default: return 7'd64;
        endcase
    endfunction

    initial begin
        int         phase, r, n;
        logic [6:0] count;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < 64; r++)
            queue_beat(CMD_LOAD, 6'(r), (r == 0) ? 64'd0 : (r == 63) ? '1 : rand_row(),
                       pick_distinct(64, 0));
        long_hold_req = 1'b1;

        queue_beat(CMD_TEST, 6'd0, 64'd0, {6'd63, 6'd62, 6'd61, 6'd60});
        queue_beat(CMD_TEST, 6'd63, '1, {6'd3, 6'd2, 6'd1, 6'd0});
        queue_beat(CMD_TEST, 6'd0, 64'd0, {6'd7, 6'd6, 6'd5, 6'd5});
        queue_beat(CMD_TEST, 6'd0, 64'd0, {6'd9, 6'd11, 6'd10, 6'd9});
        queue_beat(CMD_MASK, 6'd0, 64'd0, {6'd0, 6'd1, 6'd63, 6'd0});
        queue_beat(CMD_MASK, 6'd0, 64'd0, {6'd63, 6'd3, 6'd2, 6'd2});
        queue_beat(CMD_UNUSED, 6'd63, '1, {4{6'd63}});
        queue_beat(CMD_LOAD, 6'd63, 64'd0, {4{6'd63}});
        queue_beat(CMD_MASK, 6'd0, '1, {6'd0, 6'd63, 6'd62, 6'd61});
        queue_beat(CMD_LOAD, 6'd0, '1, '0);
        queue_beat(CMD_TEST, 6'd0, 64'd0, {6'd0, 6'd62, 6'd63, 6'd1});
        queue_beat(CMD_MASK, 6'd0, 64'd0, {6'd5, 6'd0, 6'd2, 6'd1});
        queue_beat(CMD_LOAD, 6'd1, 64'd0, '1);
        queue_beat(CMD_MASK, 6'd0, 64'd0, {6'd0, 6'd2, 6'd1, 6'd0});

        for (phase = 0; phase < PHASES; phase++) begin
            count = phase_count(phase);
            if (phase != 0) write_count_reg(count);
            case (phase % 4)
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                3: begin send_idle_pct = 38; recv_stall_pct = 38; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            n = (count > 7'd64) ? 64 : int'(count);
            queued_in_phase = 0;
            while (queued_in_phase < PHASE_BEATS) begin
                if (n >= 5 && $urandom_range(3) != 0) queue_planted_graph(n);
                else queue_noise_beat(n);
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (awaited_outcomes.size() != 0) begin
            $error("%0d expected results never arrived", awaited_outcomes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fvsc_pkg.sv
rtl/core/four_vertex_switching_check_core.sv
verif/tb_four_vertex_switching_check_core.sv
